[rtl/rau_pkg.sv]
// Package for the rational arithmetic unit: operation and status codes,
// shared widths and the divider command and response structs. No dependencies.
package rau_pkg;

    localparam int FRAC_WIDTH_DEF = 32;
    localparam int WIDE_W         = 64;
    localparam int CNT_W          = 7;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_LESS = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIVZERO  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // Divider command from the sequencer
    typedef struct packed {
        logic              start;
        logic [WIDE_W-1:0] dividend;
        logic [WIDE_W-1:0] divisor;
    } div_cmd_t;

    // Divider result back to the sequencer
    typedef struct packed {
        logic              done;
        logic [WIDE_W-1:0] quot;
        logic [WIDE_W-1:0] rem;
    } div_rsp_t;

endpackage

[rtl/rau_divider.sv]
// Shared restoring divider, one quotient bit per cycle over 64-bit operands.
// Depends on rau_pkg.
module rau_divider
    import rau_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_cmd_t cmd,
    output div_rsp_t rsp
);

    logic [WIDE_W-1:0] quot_reg, quot_next;
    logic [WIDE_W-1:0] rem_reg, rem_next;
    logic [WIDE_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WIDE_W:0]   trial;
    logic [WIDE_W:0]   diff;

    // Load operands on start, else shift one dividend bit into the remainder and try a subtract
    always_comb begin
        trial      = {rem_reg, quot_reg[WIDE_W-1]};
        diff       = trial - {1'b0, dsr_reg};
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (cmd.start) begin
            quot_next = cmd.dividend;
            rem_next  = '0;
            dsr_next  = cmd.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (diff[WIDE_W]) begin
                rem_next = trial[WIDE_W-1:0];
                quot_next = {quot_reg[WIDE_W-2:0], 1'b0};
            end else begin
                rem_next = diff[WIDE_W-1:0];
                quot_next = {quot_reg[WIDE_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WIDE_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

[rtl/rational_arithmetic_unit.sv]
// Rational arithmetic unit: add, subtract, multiply, divide and less-than on
// fractions with GCD reduction. An item is accepted only while the block is idle
// (s_ready high). One 32x32 multiplier forms the products in states S_MUL0,
// S_MUL1 and S_MUL2, and S_FORM then forms the numerator and denominator.
// Compares, zero results, undefined operations and divide-by-zero errors then go
// from S_FORM straight to the output. Every other item runs Euclid on the shared
// restoring divider. At least one Euclid step runs, and the number of steps grows
// with the operands, up to about 90 steps for 63-bit magnitudes. Two reduction
// divides then divide the numerator and denominator magnitudes by the GCD. A
// result holds in the output register until taken, and s_ready returns the
// cycle after that.
// Depends on rau_pkg and rau_divider.
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int FRAC_WIDTH = FRAC_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic signed [31:0] s_a_num,
    input  logic [30:0] s_a_den,
    input  logic signed [31:0] s_b_num,
    input  logic [30:0] s_b_den,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_res_num,
    output logic [30:0] m_res_den,
    output logic        m_is_less,
    output logic [1:0]  m_status
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MUL0  = 10'b0000000010,
        S_MUL1  = 10'b0000000100,
        S_MUL2  = 10'b0000001000,
        S_FORM  = 10'b0000010000,
        S_GCD   = 10'b0000100000,
        S_GWAIT = 10'b0001000000,
        S_NWAIT = 10'b0010000000,
        S_DWAIT = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    localparam logic [WIDE_W-1:0] LIM = WIDE_W'(1) << (FRAC_WIDTH - 1);

    state_t state_reg, state_next;
    logic [2:0]  op_reg;
    logic signed [31:0] an_reg, bn_reg;
    logic [30:0] ad_reg, bd_reg;
    logic signed [WIDE_W-1:0] p0_reg, p1_reg, p2_reg;
    logic [WIDE_W-1:0] x_reg, y_reg, mn_reg, md_reg;
    logic neg_reg;
    logic signed [31:0] rnum_reg;
    logic [30:0] rden_reg;
    logic less_reg;
    logic [1:0] st_reg;
    div_cmd_t cmd;
    div_rsp_t rsp;
    logic signed [WIDE_W-1:0] num_w;
    logic [WIDE_W-1:0] num_mag, den_mag;
    logic early_w;
    logic ovf_w;
    logic signed [31:0] mul_a, mul_b;
    logic signed [WIDE_W-1:0] mul_p;

    rau_divider u_div (.aclk(aclk), .aresetn(aresetn), .cmd(cmd), .rsp(rsp));

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = (state_reg == S_OUT);
    assign m_res_num = rnum_reg;
    assign m_res_den = rden_reg;
    assign m_is_less = less_reg;
    assign m_status  = st_reg;

    // One 32x32 signed product per cycle
    always_comb begin
        mul_a = an_reg;
        mul_b = signed'({1'b0, bd_reg});
        if (state_reg == S_MUL1) begin
            mul_a = bn_reg;
            mul_b = signed'({1'b0, ad_reg});
        end else if (state_reg == S_MUL2) begin
            mul_a = signed'({1'b0, ad_reg});
            mul_b = (op_reg == OP_DIV) ? bn_reg : signed'({1'b0, bd_reg});
        end else if (op_reg == OP_MUL) begin
            mul_b = bn_reg;
        end
        mul_p = WIDE_W'(mul_a) * WIDE_W'(mul_b);
    end

    // Pick numerator from the products, form magnitudes, early-exit and overflow flags; the denominator is always p2
    always_comb begin
        unique case (op_reg)
            OP_ADD:  num_w = p0_reg + p1_reg;
            OP_SUB:  num_w = p0_reg - p1_reg;
            default: num_w = p0_reg;
        endcase
        num_mag = num_w[WIDE_W-1] ? WIDE_W'(-num_w) : WIDE_W'(num_w);
        den_mag = p2_reg[WIDE_W-1] ? WIDE_W'(-p2_reg) : WIDE_W'(p2_reg);
        early_w = (op_reg > OP_LESS) || (ad_reg == '0) || (bd_reg == '0)
                  || (op_reg == OP_LESS) || (op_reg == OP_DIV && bn_reg == '0)
                  || (num_w == '0);
        ovf_w   = (rsp.quot >= LIM) || (neg_reg ? (mn_reg > LIM) : (mn_reg >= LIM));
    end

    // Drive divider command: Euclid step, then numerator and denominator reduction
    always_comb begin
        cmd.start    = 1'b0;
        cmd.dividend = x_reg;
        cmd.divisor  = y_reg;
        if (state_reg == S_GCD) begin
            cmd.start = 1'b1;
            if (y_reg == '0) begin
                cmd.dividend = mn_reg;
                cmd.divisor  = x_reg;
            end
        end else if (state_reg == S_NWAIT) begin
            cmd.start    = rsp.done;
            cmd.dividend = md_reg;
            cmd.divisor  = x_reg;
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_valid) state_next = S_MUL0;
            S_MUL0:  state_next = S_MUL1;
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_FORM;
            S_FORM:  state_next = early_w ? S_OUT : S_GCD;
            S_GCD:   state_next = (y_reg == '0) ? S_NWAIT : S_GWAIT;
            S_GWAIT: if (rsp.done) state_next = S_GCD;
            S_NWAIT: if (rsp.done) state_next = S_DWAIT;
            S_DWAIT: if (rsp.done) state_next = S_OUT;
            S_OUT:   if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        // Capture the item
        if (state_reg == S_IDLE && s_valid) begin
            op_reg <= s_operation;
            an_reg <= s_a_num;
            bn_reg <= s_b_num;
            ad_reg <= s_a_den;
            bd_reg <= s_b_den;
        end
        if (state_reg == S_MUL0) p0_reg <= mul_p;
        if (state_reg == S_MUL1) p1_reg <= mul_p;
        if (state_reg == S_MUL2) p2_reg <= mul_p;
        // Settle special cases and seed Euclid with the magnitudes
        if (state_reg == S_FORM) begin
            neg_reg  <= num_w[WIDE_W-1] != p2_reg[WIDE_W-1];
            mn_reg   <= num_mag;
            md_reg   <= den_mag;
            x_reg    <= num_mag;
            y_reg    <= den_mag;
            less_reg <= 1'b0;
            rnum_reg <= '0;
            rden_reg <= 31'd1;
            st_reg   <= ST_OK;
            if (op_reg <= OP_LESS) begin
                if (ad_reg == '0 || bd_reg == '0) begin
                    st_reg <= ST_DIVZERO;
                end else if (op_reg == OP_LESS) begin
                    less_reg <= (p0_reg < p1_reg);
                end else if (op_reg == OP_DIV && bn_reg == '0) begin
                    st_reg <= ST_DIVZERO;
                end
            end
        end
        // Advance Euclid
        if (state_reg == S_GWAIT && rsp.done) begin
            x_reg <= y_reg;
            y_reg <= rsp.rem;
        end
        if (state_reg == S_NWAIT && rsp.done) begin
            mn_reg <= rsp.quot;
        end
        // Check range and load the result
        if (state_reg == S_DWAIT && rsp.done) begin
            if (ovf_w) begin
                st_reg <= ST_OVERFLOW;
            end else begin
                rnum_reg <= neg_reg ? 32'(-mn_reg) : 32'(mn_reg);
                rden_reg <= 31'(rsp.quot);
            end
        end
    end

endmodule

[rtl/rau_checker.sv]
// Port checker for the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg.
module rau_checker
    import rau_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [30:0] m_res_den,
    input logic [1:0]  m_status
);

    // Hold a result until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");

    // Accept no item while a result waits
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("accepted while result pending");

    // Drop ready after taking an item
    a_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("ready held after accept");

    // Keep denominator nonzero
    a_den: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_res_den != '0) else $error("zero denominator");

    // Use only defined status codes
    a_st: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != 2'd3) else $error("bad status");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_res_den(m_res_den),
    .m_status(m_status)
);
